// ===== sv/mono_framebuffer_draw_engine_core_defines.svh =====
// Assertion macros shared by the draw engine modules
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_CORE_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_CORE_DEFINES_SVH
// concurrent check, clocked on rising clk, muted while in reset
`define MFDE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition that must never be true on a rising clk outside reset
`define MFDE_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`endif

// ===== sv/mfde_pkg.sv =====
// Shared types and constants of the frame store draw engine
package mfde_pkg;

  typedef enum logic [2:0] {
    CMD_SET    = 3'd0,
    CMD_CLR    = 3'd1,
    CMD_LINE   = 3'd2,
    CMD_CIRCLE = 3'd3,
    CMD_CLS    = 3'd4,
    CMD_READ   = 3'd5,
    CMD_NOP6   = 3'd6,
    CMD_NOP7   = 3'd7
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLS,
    ST_LSETUP,
    ST_LDIV,
    ST_LINE,
    ST_CSTEP,
    ST_CTEST,
    ST_CPLOT,
    ST_CADV,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RD,
    ST_RD2,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       load;       // capture the command beat
    logic       cls_start;  // zero the sweep counter
    logic       cls_write;  // write zero at sweep address, advance
    logic       line_setup; // compute dx, dy, start division
    logic       div_step;   // one restoring division step
    logic       line_pt;    // latch current line point as pending pixel
    logic       line_adv;   // advance line index
    logic       circ_init;  // a = 0, b = r
    logic       circ_chk;   // register the loop test
    logic       circ_pt;    // latch symmetric point (oct)
    logic       circ_adv;   // a++, with b-- / a-- correction
    logic       pix_single; // latch single pixel command
    logic       rmw_rd;     // issue memory read for pending pixel
    logic       rmw_wr;     // write modified byte
    logic       rd_issue;   // issue memory read for read command
    logic       rd_cap;     // capture read data
    logic [2:0] oct;        // symmetric point index
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       cls_last;
    logic       line_rej;
    logic       line_empty;
    logic       div_done;
    logic       line_last;
    logic       circ_zero;
    logic       circ_go;
    logic       pix_ok;
  } sts_t;

endpackage

// ===== sv/mono_framebuffer_draw_engine_core.sv =====
// Top level of the monochrome frame store draw engine
// channel | valid        | stall        | payload
// in      | in_valid_i   | in_stall_o   | cmd_i x_start_i y_start_i x_end_i y_end_i radius_i
// out     | out_valid_o  | out_stall_i  | read_data_o rejected_o
// Pixel commands do one read-modify-write, a read one store read; a line divides, then one RMW per pixel.
// A circle runs its step test each step, then one RMW per plotted point; one store port sets the pace.
// Clear screen walks all ScreenWidth * pages bytes of the store, one byte a cycle.
// After reset the same sweep runs before the first beat is taken.
// The result beat holds while out_stall_i is high; no new beat is taken until it leaves.
module mono_framebuffer_draw_engine_core #(
  parameter int unsigned ScreenWidth  = 128,
  parameter int unsigned ScreenHeight = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] x_start_i,
  input  logic [7:0] y_start_i,
  input  logic [7:0] x_end_i,
  input  logic [7:0] y_end_i,
  input  logic [6:0] radius_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       rejected_o
);
  mfde_pkg::ctl_t ctl;
  mfde_pkg::sts_t sts;

  mfde_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  mfde_datapath #(.ScreenWidth(ScreenWidth), .ScreenHeight(ScreenHeight)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts),
    .cmd_i, .x_start_i, .y_start_i, .x_end_i, .y_end_i, .radius_i,
    .read_data_o, .rejected_o
  );
endmodule

// ===== sv/mfde_datapath.sv =====
// Datapath: frame store, line and circle arithmetic, pixel read-modify-write
`include "mono_framebuffer_draw_engine_core_defines.svh"
module mfde_datapath #(
  parameter int unsigned ScreenWidth  = 128,
  parameter int unsigned ScreenHeight = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mfde_pkg::ctl_t ctl_i,
  output mfde_pkg::sts_t sts_o,
  input  logic [2:0]    cmd_i,
  input  logic [7:0]    x_start_i,
  input  logic [7:0]    y_start_i,
  input  logic [7:0]    x_end_i,
  input  logic [7:0]    y_end_i,
  input  logic [6:0]    radius_i,
  output logic [7:0]    read_data_o,
  output logic          rejected_o
);
  localparam int unsigned Pages = (ScreenHeight + 7) / 8;
  localparam int unsigned Depth = ScreenWidth * Pages;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0] mem [Depth];

  logic [2:0] cmd_q;
  logic [7:0] xs_q, ys_q, xe_q, ye_q;
  logic [6:0] r_q;

  // pending pixel (signed, 10 bits covers -127..382)
  logic signed [9:0] px_q, py_q;
  logic              pon_q;
  logic [AW-1:0]     addr_q;
  logic [7:0]        rdat_q;
  logic [7:0]        read_data_q;
  logic              rej_q;
  logic [AW:0]       cls_q;

  // line
  logic [7:0]  dx_q, dy_q, li_q;
  logic [11:0] num_q;      // dividend shift register (dy*10 <= 2560)
  logic [11:0] rem_q;
  logic [11:0] k_q;
  logic [3:0]  dcnt_q;
  logic [19:0] ik_q;       // i*k accumulated
  logic [1:0]  lmode_q;    // 0 vertical,1 horizontal,2 sloped

  // circle
  logic signed [8:0] ca_q, cb_q;
  logic              cgo_q;

  // pixel validity and address
  logic pix_ok;
  logic [AW-1:0] pix_addr;
  always_comb begin
    pix_ok = (px_q >= 0) && (py_q >= 0) &&
             (px_q < $signed(10'(ScreenWidth))) && (py_q < $signed(10'(ScreenHeight)));
    pix_addr = AW'(32'(px_q[8:0]) * Pages + 32'(py_q[8:3]));
  end

  // next line pixel
  logic signed [9:0] lpx, lpy;
  logic [19:0] ikdiv;
  always_comb begin
    // reciprocal of ten, exact for any 20-bit value
    ikdiv = 20'((40'(ik_q) * 40'd838861) >> 23);
    lpx = $signed({2'b00, xs_q}) + $signed({2'b00, (lmode_q == 2'd0) ? 8'd0 : li_q});
    case (lmode_q)
      2'd0:    lpy = $signed({2'b00, ys_q}) + $signed({2'b00, li_q});
      2'd1:    lpy = $signed({2'b00, ys_q});
      default: lpy = $signed({2'b00, ys_q}) + $signed({2'b0, ikdiv[7:0]});
    endcase
  end

  // circle points
  logic signed [9:0] cx, cy, ca, cb;
  always_comb begin
    ca = 10'(ca_q);
    cb = 10'(cb_q);
    case (ctl_i.oct)
      3'd0:    begin cx = $signed({2'b0, xs_q}) + ca; cy = $signed({2'b0, ys_q}) - cb; end
      3'd1:    begin cx = $signed({2'b0, xs_q}) - ca; cy = $signed({2'b0, ys_q}) - cb; end
      3'd2:    begin cx = $signed({2'b0, xs_q}) - ca; cy = $signed({2'b0, ys_q}) + cb; end
      3'd3:    begin cx = $signed({2'b0, xs_q}) + ca; cy = $signed({2'b0, ys_q}) + cb; end
      3'd4:    begin cx = $signed({2'b0, xs_q}) + cb; cy = $signed({2'b0, ys_q}) + ca; end
      3'd5:    begin cx = $signed({2'b0, xs_q}) + cb; cy = $signed({2'b0, ys_q}) - ca; end
      3'd6:    begin cx = $signed({2'b0, xs_q}) - cb; cy = $signed({2'b0, ys_q}) - ca; end
      default: begin cx = $signed({2'b0, xs_q}) - cb; cy = $signed({2'b0, ys_q}) + ca; end
    endcase
  end

  // circle step tests (narrow, 18-bit signed squares)
  logic signed [17:0] rr, bb2, aab;
  logic signed [8:0]  an;
  always_comb begin
    rr  = 18'(r_q) * 18'(r_q);
    bb2 = (18'(cb_q) * 18'(cb_q)) <<< 1;
    an  = ca_q + 9'sd1;
    aab = 18'(an) * 18'(an) + 18'(cb_q) * 18'(cb_q) - rr;
  end

  logic [11:0] rem_sh;
  always_comb rem_sh = {rem_q[10:0], num_q[11]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q <= '0;
      rej_q <= 1'b0;
      read_data_q <= '0;
      cgo_q <= 1'b0;
    end else begin
      if (ctl_i.load) begin
        cmd_q <= cmd_i; xs_q <= x_start_i; ys_q <= y_start_i;
        xe_q <= x_end_i; ye_q <= y_end_i; r_q <= radius_i;
        rej_q <= 1'b0; read_data_q <= '0;
      end
      if (ctl_i.cls_start) cls_q <= '0;
      if (ctl_i.cls_write) cls_q <= cls_q + 1'b1;
      if (ctl_i.line_setup) begin
        rej_q   <= sts_o.line_rej;
        dx_q    <= xe_q - xs_q;
        dy_q    <= ye_q - ys_q;
        num_q   <= 12'(12'(ye_q - ys_q) * 12'd10);
        rem_q   <= '0;
        k_q     <= '0;
        dcnt_q  <= '0;
        li_q    <= '0;
        ik_q    <= '0;
        lmode_q <= (xe_q == xs_q) ? 2'd0 : (ye_q == ys_q) ? 2'd1 : 2'd2;
      end
      if (ctl_i.div_step) begin
        num_q  <= {num_q[10:0], 1'b0};
        dcnt_q <= dcnt_q + 4'd1;
        if (rem_sh >= 12'(dx_q)) begin
          rem_q <= rem_sh - 12'(dx_q);
          k_q   <= {k_q[10:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          k_q   <= {k_q[10:0], 1'b0};
        end
      end
      if (ctl_i.line_pt) begin
        px_q <= lpx; py_q <= lpy; pon_q <= 1'b1;
      end
      if (ctl_i.line_adv) begin
        li_q <= li_q + 8'd1;
        ik_q <= ik_q + 20'(k_q);
      end
      if (ctl_i.circ_init) begin
        ca_q <= '0;
        cb_q <= 9'(r_q);
      end
      if (ctl_i.circ_chk) cgo_q <= (bb2 >= rr);
      if (ctl_i.circ_pt) begin
        px_q <= cx; py_q <= cy; pon_q <= 1'b1;
      end
      if (ctl_i.circ_adv) begin
        if (aab > 0) cb_q <= cb_q - 9'sd1;
        else ca_q <= an;
      end
      if (ctl_i.pix_single) begin
        px_q  <= $signed({2'b0, xs_q});
        py_q  <= $signed({2'b0, ys_q});
        // radius zero circle plots its centre
        pon_q <= (cmd_q == mfde_pkg::CMD_SET) || (cmd_q == mfde_pkg::CMD_CIRCLE);
      end
      if (ctl_i.rd_cap) read_data_q <= rdat_q;
    end
  end

  // read-modify-write and read command share one port pair
  logic [AW-1:0] rd_addr;
  logic          rd_ok;
  always_comb begin
    rd_ok   = (32'(xs_q) < ScreenWidth) && (32'(ys_q[7:3]) < Pages);
    rd_addr = AW'(32'(xs_q) * Pages + 32'(ys_q[7:3]));
  end

  logic [7:0] mask, wdat;
  always_comb begin
    mask = 8'd1 << py_q[2:0];
    wdat = pon_q ? (rdat_q | mask) : (rdat_q & ~mask);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rmw_rd) begin
      rdat_q <= mem[pix_addr];
      addr_q <= pix_addr;
    end else if (ctl_i.rd_issue) begin
      rdat_q <= rd_ok ? mem[rd_addr] : 8'd0;
    end
    if (ctl_i.cls_write) mem[cls_q[AW-1:0]] <= 8'd0;
    else if (ctl_i.rmw_wr) mem[addr_q] <= wdat;
  end

  always_comb begin
    sts_o.cmd        = cmd_q;
    sts_o.cls_last   = (32'(cls_q) == Depth - 1);
    sts_o.line_rej   = (32'(xe_q) > ScreenWidth) || (32'(ye_q) > ScreenHeight) ||
                       (xs_q > xe_q) || (ys_q > ye_q);
    sts_o.line_empty = (dx_q == 8'd0) ? (dy_q == 8'd0) : 1'b0;
    sts_o.div_done   = (dcnt_q == 4'd12);
    sts_o.line_last  = (lmode_q == 2'd0) ? (li_q + 8'd1 >= dy_q) : (li_q + 8'd1 >= dx_q);
    sts_o.circ_zero  = (r_q == 7'd0);
    sts_o.circ_go    = cgo_q;
    sts_o.pix_ok     = pix_ok;
  end

  assign read_data_o = read_data_q;
  assign rejected_o  = rej_q;

  `MFDE_ASSERT(a_rej_only_line, clk_i, rst_ni,
    rej_q |-> (cmd_q == mfde_pkg::CMD_LINE))
  `MFDE_ASSERT(a_rd_only_read, clk_i, rst_ni,
    (read_data_q != 8'd0) |-> (cmd_q == mfde_pkg::CMD_READ))
  `MFDE_ASSERT_NEVER(a_no_dual_write, clk_i, rst_ni,
    ctl_i.cls_write && ctl_i.rmw_wr)
endmodule

// ===== sv/mfde_ctrl.sv =====
// Controller state machine sequencing commands through the datapath
`include "mono_framebuffer_draw_engine_core_defines.svh"
module mfde_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  mfde_pkg::sts_t sts_i,
  output mfde_pkg::ctl_t ctl_o
);
  mfde_pkg::state_e state_q, state_d;
  mfde_pkg::state_e ret_q, ret_d;
  logic [2:0] oct_q, oct_d;
  logic       busy_q, busy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfde_pkg::ST_CLS;
      ret_q   <= mfde_pkg::ST_IDLE;
      oct_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      oct_q   <= oct_d;
      busy_q  <= busy_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    oct_d       = oct_q;
    busy_d      = busy_q;
    ctl_o       = '0;
    ctl_o.oct   = oct_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      mfde_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          busy_d     = 1'b1;
          state_d    = mfde_pkg::ST_LSETUP;
        end
      end
      mfde_pkg::ST_LSETUP: begin
        ret_d = mfde_pkg::ST_OUT;
        case (sts_i.cmd)
          mfde_pkg::CMD_SET, mfde_pkg::CMD_CLR: begin
            ctl_o.pix_single = 1'b1;
            state_d = mfde_pkg::ST_RMW_RD;
          end
          mfde_pkg::CMD_LINE: begin
            ctl_o.line_setup = 1'b1;
            state_d = sts_i.line_rej ? mfde_pkg::ST_OUT : mfde_pkg::ST_LDIV;
          end
          mfde_pkg::CMD_CIRCLE: begin
            if (sts_i.circ_zero) begin
              ctl_o.pix_single = 1'b1;
              state_d = mfde_pkg::ST_RMW_RD;
            end else begin
              ctl_o.circ_init = 1'b1;
              state_d = mfde_pkg::ST_CSTEP;
            end
          end
          mfde_pkg::CMD_CLS: begin
            ctl_o.cls_start = 1'b1;
            state_d = mfde_pkg::ST_CLS;
          end
          mfde_pkg::CMD_READ: begin
            ctl_o.rd_issue = 1'b1;
            state_d = mfde_pkg::ST_RD;
          end
          default: state_d = mfde_pkg::ST_OUT;
        endcase
      end
      mfde_pkg::ST_CLS: begin
        ctl_o.cls_write = 1'b1;
        if (sts_i.cls_last) state_d = busy_q ? mfde_pkg::ST_OUT : mfde_pkg::ST_IDLE;
      end
      mfde_pkg::ST_LDIV: begin
        if (sts_i.div_done) begin
          state_d = sts_i.line_empty ? mfde_pkg::ST_OUT : mfde_pkg::ST_LINE;
        end else begin
          ctl_o.div_step = 1'b1;
        end
      end
      mfde_pkg::ST_LINE: begin
        ctl_o.line_pt = 1'b1;
        ret_d   = sts_i.line_last ? mfde_pkg::ST_OUT : mfde_pkg::ST_LINE;
        state_d = mfde_pkg::ST_RMW_RD;
        ctl_o.line_adv = 1'b1;
      end
      mfde_pkg::ST_CSTEP: begin
        ctl_o.circ_chk = 1'b1;
        state_d = mfde_pkg::ST_CTEST;
      end
      mfde_pkg::ST_CTEST: begin
        oct_d   = '0;
        state_d = sts_i.circ_go ? mfde_pkg::ST_CPLOT : mfde_pkg::ST_OUT;
      end
      mfde_pkg::ST_CPLOT: begin
        ctl_o.circ_pt = 1'b1;
        oct_d   = oct_q + 3'd1;
        ret_d   = (oct_q == 3'd7) ? mfde_pkg::ST_CADV : mfde_pkg::ST_CPLOT;
        state_d = mfde_pkg::ST_RMW_RD;
      end
      mfde_pkg::ST_CADV: begin
        ctl_o.circ_adv = 1'b1;
        state_d = mfde_pkg::ST_CSTEP;
      end
      mfde_pkg::ST_RMW_RD: begin
        if (sts_i.pix_ok) begin
          ctl_o.rmw_rd = 1'b1;
          state_d = mfde_pkg::ST_RMW_WR;
        end else begin
          state_d = ret_q;
        end
      end
      mfde_pkg::ST_RMW_WR: begin
        ctl_o.rmw_wr = 1'b1;
        state_d = ret_q;
      end
      mfde_pkg::ST_RD: state_d = mfde_pkg::ST_RD2;
      mfde_pkg::ST_RD2: begin
        ctl_o.rd_cap = 1'b1;
        state_d = mfde_pkg::ST_OUT;
      end
      mfde_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          busy_d  = 1'b0;
          state_d = mfde_pkg::ST_IDLE;
        end
      end
      default: state_d = mfde_pkg::ST_IDLE;
    endcase
  end

  `MFDE_ASSERT(a_out_holds, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> out_valid_o)
  `MFDE_ASSERT(a_accept_idle, clk_i, rst_ni,
    (!in_stall_o) |-> (state_q == mfde_pkg::ST_IDLE))
  `MFDE_ASSERT(a_out_busy, clk_i, rst_ni,
    out_valid_o |-> busy_q)
endmodule

// ===== test/tb.sv =====
// Testbench for the monochrome frame store draw engine: scoreboard and stimulus
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Width  = 128;
  localparam int Height = 64;
  localparam int Pages  = (Height + 7) / 8;
  localparam int WatchdogLimit = 200000;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rejected;
  } draw_result_t;

  // shadow frame store and queue of pending results
  class draw_scoreboard;
    logic [7:0] shadow_store [Width*Pages];
    draw_result_t pending_results[$];
    int mismatch_count;
    int result_count;

    function void clear_shadow();
      foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    endfunction

    function void plot(int x, int y, bit on);
      int idx;
      if (x < 0 || y < 0 || x >= Width || y >= Height) return;
      idx = x * Pages + y / 8;
      if (on) shadow_store[idx] |= 8'(1 << (y % 8));
      else shadow_store[idx] &= ~8'(1 << (y % 8));
    endfunction

    function bit trace_line(int x1, int y1, int x2, int y2);
      int dx, dy, slope;
      if (x2 > Width || y2 > Height || x1 > x2 || y1 > y2) return 1'b1;
      dx = x2 - x1;
      dy = y2 - y1;
      if (dx == 0) begin
        for (int i = 0; i < dy; i++) plot(x1, y1 + i, 1'b1);
      end else if (dy == 0) begin
        for (int i = 0; i < dx; i++) plot(x1 + i, y1, 1'b1);
      end else begin
        slope = (dy * 10) / dx;
        for (int i = 0; i < dx; i++) plot(x1 + i, y1 + (i * slope) / 10, 1'b1);
      end
      return 1'b0;
    endfunction

    function void trace_circle(int x, int y, int r);
      int a, b;
      a = 0;
      b = r;
      if (r == 0) begin
        plot(x, y, 1'b1);
        return;
      end
      while (2 * b * b >= r * r) begin
        plot(x + a, y - b, 1'b1); plot(x - a, y - b, 1'b1);
        plot(x - a, y + b, 1'b1); plot(x + a, y + b, 1'b1);
        plot(x + b, y + a, 1'b1); plot(x + b, y - a, 1'b1);
        plot(x - b, y - a, 1'b1); plot(x - b, y + a, 1'b1);
        a++;
        if (a * a + b * b - r * r > 0) begin
          b--;
          a--;
        end
      end
    endfunction

    function void note_command(mfde_pkg::cmd_e cmd, int xs, int ys, int xe, int ye,
                               int rad);
      draw_result_t res;
      res = '0;
      case (cmd)
        mfde_pkg::CMD_SET:    plot(xs, ys, 1'b1);
        mfde_pkg::CMD_CLR:    plot(xs, ys, 1'b0);
        mfde_pkg::CMD_LINE:   res.rejected = trace_line(xs, ys, xe, ye);
        mfde_pkg::CMD_CIRCLE: trace_circle(xs, ys, rad);
        mfde_pkg::CMD_CLS:    clear_shadow();
        mfde_pkg::CMD_READ: begin
          if (xs < Width && ys / 8 < Pages) res.read_data = shadow_store[xs * Pages + ys / 8];
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [7:0] read_data, logic rejected);
      draw_result_t exp_res;
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat read_data=%h rejected=%b",
                 $realtime, read_data, rejected);
        mismatch_count++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (read_data !== exp_res.read_data) begin
        $display("%0t: read_data expected %h actual %h", $realtime, exp_res.read_data,
                 read_data);
        mismatch_count++;
      end
      if (rejected !== exp_res.rejected) begin
        $display("%0t: rejected expected %b actual %b", $realtime, exp_res.rejected,
                 rejected);
        mismatch_count++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] cmd_i = '0;
  logic [7:0] x_start_i = '0;
  logic [7:0] y_start_i = '0;
  logic [7:0] x_end_i = '0;
  logic [7:0] y_end_i = '0;
  logic [6:0] radius_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] read_data_o;
  logic       rejected_o;

  draw_scoreboard scoreboard = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int cmd_counts[8];

  mono_framebuffer_draw_engine_core #(
    .ScreenWidth (Width),
    .ScreenHeight(Height)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .x_start_i  (x_start_i),
    .y_start_i  (y_start_i),
    .x_end_i    (x_end_i),
    .y_end_i    (y_end_i),
    .radius_i   (radius_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .read_data_o(read_data_o),
    .rejected_o (rejected_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stall, check accepted beats; watchdog on idle cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) scoreboard.check_result(read_data_o, rejected_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // valid drops only while idling, so back-to-back beats keep it high
  task automatic send_command(mfde_pkg::cmd_e cmd, int xs, int ys, int xe, int ye,
                              int rad);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    x_start_i  <= 8'(xs);
    y_start_i  <= 8'(ys);
    x_end_i    <= 8'(xe);
    y_end_i    <= 8'(ye);
    radius_i   <= 7'(rad);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    scoreboard.note_command(cmd, xs, ys, xe, ye, rad);
    cmd_counts[cmd]++;
  endtask

  task automatic send_random_command();
    int pick, xs, ys, xe, ye;
    pick = $urandom_range(99);
    xs = $urandom_range(255);
    ys = $urandom_range(255);
    if (pick < 25) begin
      // pixels mostly on screen so reads find them
      if ($urandom_range(3) != 0) begin
        xs = $urandom_range(Width - 1);
        ys = $urandom_range(Height - 1);
      end
      send_command($urandom_range(1) ? mfde_pkg::CMD_SET : mfde_pkg::CMD_CLR, xs, ys,
                   $urandom_range(255), $urandom_range(255), $urandom_range(127));
    end else if (pick < 45) begin
      if ($urandom_range(4) != 0) begin
        xs = $urandom_range(Width);
        ys = $urandom_range(Height);
        xe = xs + $urandom_range(Width - xs);
        ye = ys + $urandom_range(Height - ys);
        if ($urandom_range(5) == 0) xe = xs;
        else if ($urandom_range(5) == 0) ye = ys;
      end else begin
        xe = $urandom_range(255);
        ye = $urandom_range(255);
      end
      send_command(mfde_pkg::CMD_LINE, xs, ys, xe, ye, $urandom_range(127));
    end else if (pick < 60) begin
      if ($urandom_range(3) != 0) begin
        xs = $urandom_range(Width - 1);
        ys = $urandom_range(Height - 1);
      end
      send_command(mfde_pkg::CMD_CIRCLE, xs, ys, $urandom_range(255), $urandom_range(255),
                   ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(40));
    end else if (pick < 62) begin
      send_command(mfde_pkg::CMD_CLS, xs, ys, $urandom_range(255), $urandom_range(255),
                   $urandom_range(127));
    end else if (pick < 96) begin
      if ($urandom_range(7) != 0) begin
        xs = $urandom_range(Width - 1);
        ys = $urandom_range(Height - 1);
      end
      send_command(mfde_pkg::CMD_READ, xs, ys, $urandom_range(255), $urandom_range(255),
                   $urandom_range(127));
    end else begin
      send_command($urandom_range(1) ? mfde_pkg::CMD_NOP6 : mfde_pkg::CMD_NOP7, xs, ys,
                   $urandom_range(255), $urandom_range(255), $urandom_range(127));
    end
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (scoreboard.pending_results.size() != 0 && guard < WatchdogLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int idle_pct [4] = '{0, 83, 0, 30};
    int stall_pct[4] = '{0, 0, 83, 30};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every command, guard cases, radius zero, off-screen reads
    send_command(mfde_pkg::CMD_SET, 0, 0, 0, 0, 0);
    send_command(mfde_pkg::CMD_SET, Width - 1, Height - 1, 255, 255, 127);
    send_command(mfde_pkg::CMD_READ, 0, 0, 0, 0, 0);
    send_command(mfde_pkg::CMD_READ, Width - 1, Height - 1, 0, 0, 0);
    send_command(mfde_pkg::CMD_CLR, 0, 0, 0, 0, 0);
    send_command(mfde_pkg::CMD_SET, 255, 255, 0, 0, 0);
    send_command(mfde_pkg::CMD_READ, 255, 255, 255, 255, 127);
    send_command(mfde_pkg::CMD_READ, 10, Height, 0, 0, 0);
    send_command(mfde_pkg::CMD_LINE, 0, 0, Width, Height, 0);
    send_command(mfde_pkg::CMD_LINE, 3, 5, 3, 20, 0);
    send_command(mfde_pkg::CMD_LINE, 7, 9, 40, 9, 0);
    send_command(mfde_pkg::CMD_LINE, 20, 20, 20, 20, 0);
    send_command(mfde_pkg::CMD_LINE, 0, 0, Width + 1, 10, 0);
    send_command(mfde_pkg::CMD_LINE, 0, 0, 10, Height + 1, 0);
    send_command(mfde_pkg::CMD_LINE, 11, 0, 10, 5, 0);
    send_command(mfde_pkg::CMD_LINE, 0, 6, 10, 5, 0);
    send_command(mfde_pkg::CMD_READ, 3, 8, 0, 0, 0);
    send_command(mfde_pkg::CMD_CIRCLE, 60, 30, 0, 0, 0);
    send_command(mfde_pkg::CMD_CIRCLE, 64, 32, 0, 0, 127);
    send_command(mfde_pkg::CMD_CIRCLE, 0, 0, 0, 0, 10);
    send_command(mfde_pkg::CMD_CIRCLE, 255, 255, 0, 0, 127);
    send_command(mfde_pkg::CMD_READ, 64, 0, 0, 0, 0);
    send_command(mfde_pkg::CMD_NOP6, 1, 1, 1, 1, 1);
    send_command(mfde_pkg::CMD_NOP7, 255, 255, 255, 255, 127);
    send_command(mfde_pkg::CMD_CLS, 0, 0, 0, 0, 0);
    send_command(mfde_pkg::CMD_READ, 0, 0, 0, 0, 0);

    for (int phase = 0; phase < 5; phase++) begin
      send_idle_pct  = idle_pct[phase % 4];
      recv_stall_pct = stall_pct[phase % 4];
      for (int n = 0; n < 280; n++) send_random_command();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();

    $display("covered %0d set, %0d clear, %0d line, %0d circle, %0d clear-screen,",
             cmd_counts[0], cmd_counts[1], cmd_counts[2], cmd_counts[3], cmd_counts[4]);
    $display("%0d read and %0d unused-code beats; %0d results checked",
             cmd_counts[5], cmd_counts[6] + cmd_counts[7], scoreboard.result_count);
    if (scoreboard.mismatch_count == 0 && scoreboard.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (scoreboard.pending_results.size() != 0)
        $display("%0d results never arrived", scoreboard.pending_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/mfde_pkg.sv
sv/mfde_datapath.sv
sv/mfde_ctrl.sv
sv/mono_framebuffer_draw_engine_core.sv
test/tb.sv
